### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the running z-score block.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on clk, skipped while reset is asserted.
`define CHK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`endif

### hdl/rpzs_pkg.sv
// Package for the running z-score block: widths, status codes, sequencer states.
// No dependencies.
package rpzs_pkg;
	localparam int MaxSetLenDefault = 32;
	localparam int SampleW = 16;
	localparam int DevW = 17;
	// Datapath width for the shared divide / root unit.
	localparam int WideW = 56;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FEW = 2'd1,
		ST_ZERO = 2'd2,
		ST_LONG = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_MEAN, S_MEANW, S_DVAR, S_DVARW,
		S_SQRT, S_SQRTW, S_ZDIV, S_ZDIVW, S_OUT
	} state_t;

	// Start request and mode select of the shared unit.
	typedef struct packed {
		logic start;
		logic is_sqrt;
	} unit_ctl_t;
endpackage

### hdl/rpzs_unit.sv
// Shared iterative unit: unsigned restoring divide or integer square root,
// one result bit per cycle. Depends on rpzs_pkg.
module rpzs_unit (
	input  logic clk,
	input  logic arst_n,
	input  rpzs_pkg::unit_ctl_t ctl,
	input  logic [rpzs_pkg::WideW-1:0] num,
	input  logic [rpzs_pkg::WideW-1:0] den,
	output logic busy,
	output logic [rpzs_pkg::WideW-1:0] res
);
	localparam int W = rpzs_pkg::WideW;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0] rem_q, quo_q, den_q, bit_q, val_q;
	logic [CW-1:0] cnt_q;
	logic sqrt_q;
	logic [W:0] trial;
	logic [W-1:0] rem_sh;

	// Divide step: shift in next numerator bit, compare, subtract.
	assign rem_sh = {rem_q[W-2:0], val_q[W-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, den_q};
	assign res = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			busy <= 1'b1;
			sqrt_q <= ctl.is_sqrt;
			rem_q <= '0;
			quo_q <= '0;
			val_q <= num;
			den_q <= den;
			bit_q <= {2'b01, {(W-2){1'b0}}};
			cnt_q <= ctl.is_sqrt ? CW'(W/2) : CW'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy <= 1'b0;
			if (sqrt_q) begin
				// Bitwise root: val holds remainder, quo the root.
				if (val_q >= quo_q + bit_q) begin
					val_q <= val_q - (quo_q + bit_q);
					quo_q <= (quo_q >> 1) + bit_q;
				end else begin
					quo_q <= quo_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				val_q <= {val_q[W-2:0], 1'b0};
				if (!trial[W]) begin
					rem_q <= trial[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
			end
		end
	end
endmodule

### hdl/running_prior_z_score.sv
// Running z-score of a Q4.12 sample against the earlier samples of its set.
// Channels: s_axis carries one sample word (tdata = sample, tuser = first_of_set);
// m_axis carries one result word per sample. The sequencer drives one shared
// divide / square-root unit, one result bit per cycle. Each unit pass has a start
// state and a wait state that hands the result over: mean divide, variance
// divide, root and z divide, in that order, after the multiply states MUL1 to
// MUL3. The word is then registered in the output state. Shorter paths: with no
// prior sample the output state follows MUL1, with one prior sample it follows
// the mean divide, and with the set too long or zero deviation it follows the
// root. s_axis_tready is high only in idle, so the next word is taken no earlier
// than the cycle after the result is registered, never while a sample is in work.
// The result stays in an output register until m_axis_tready; while the
// receiver stalls the next result waits in its last step and no new sample is
// taken. Reset (arst_n low) clears count, sum and square sum and empties the
// output register.
// Depends on rpzs_pkg, rpzs_unit, assert_macros.svh.
`include "assert_macros.svh"
module running_prior_z_score #(
	parameter int MAX_SET_LEN = rpzs_pkg::MaxSetLenDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample
	input  logic s_axis_tuser,          // [0] first_of_set
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [55:0] m_axis_tdata    // [15:0] z_score, [31:16] prior_mean,
	                                    // [48:32] prior_deviation, [50:49] status, zero pad
);
	localparam int W = rpzs_pkg::WideW;
	localparam int NW = $clog2(MAX_SET_LEN + 1);
	// Sum of samples (signed) and sum of squares widths.
	localparam int SW = rpzs_pkg::SampleW + NW;
	localparam int QW = 2 * rpzs_pkg::SampleW + NW - 1;
	localparam int DW = rpzs_pkg::DevW;

	rpzs_pkg::state_t state_q, state_d;
	logic [NW-1:0] cnt_q;
	logic signed [SW-1:0] sum_q;
	logic [QW-1:0] sq_q;
	logic signed [15:0] x_q;
	logic signed [W-1:0] prod_q, acc_q;
	logic [W-1:0] den_q;
	logic neg_q, full_q;
	logic signed [15:0] mean_q, z_q;
	logic [16:0] dev_q;
	rpzs_pkg::status_t status_q;
	rpzs_pkg::unit_ctl_t ctl;
	logic [W-1:0] u_num, u_den, u_res;
	logic u_busy;
	logic [W-1:0] mag;
	logic [W-1:0] dev_r;
	logic [DW-1:0] devc;
	logic [NW+QW-1:0] nq;
	logic signed [2*SW-1:0] ss;
	logic [2*NW-1:0] nn;
	logic signed [NW+16:0] nx;
	logic [NW+DW-1:0] ndev;
	logic signed [31:0] xsq;

	rpzs_unit u_unit (.clk, .arst_n, .ctl, .num(u_num), .den(u_den),
		.busy(u_busy), .res(u_res));

	assign s_axis_tready = (state_q == rpzs_pkg::S_IDLE);
	assign mag = acc_q[W-1] ? W'(-acc_q) : W'(acc_q);
	assign dev_r = (u_res + 1'b1) >> 1;
	assign devc = (dev_r > W'(17'h1FFFF)) ? 17'h1FFFF : dev_r[DW-1:0];

	// Narrow products: n*Q, S*S, n*(n-1), n*x, n*dev, x*x.
	assign nq = cnt_q * sq_q;
	assign ss = sum_q * sum_q;
	assign nn = cnt_q * (cnt_q - 1'b1);
	assign nx = $signed({1'b0, cnt_q}) * x_q;
	assign ndev = cnt_q * devc;
	assign xsq = x_q * x_q;

	// Next state and unit start.
	always_comb begin
		state_d = state_q;
		ctl = '0;
		u_num = W'(prod_q);
		u_den = den_q;
		unique case (state_q)
			rpzs_pkg::S_IDLE: if (s_axis_tvalid) state_d = rpzs_pkg::S_MUL1;
			rpzs_pkg::S_MUL1: state_d = (cnt_q == '0) ? rpzs_pkg::S_OUT : rpzs_pkg::S_MUL2;
			rpzs_pkg::S_MUL2: state_d = rpzs_pkg::S_MUL3;
			rpzs_pkg::S_MUL3: state_d = rpzs_pkg::S_MEAN;
			rpzs_pkg::S_MEAN: begin
				ctl.start = 1'b1;
				u_num = mag + (den_q >> 1);
				state_d = rpzs_pkg::S_MEANW;
			end
			rpzs_pkg::S_MEANW: if (!u_busy)
				state_d = (cnt_q < NW'(2)) ? rpzs_pkg::S_OUT : rpzs_pkg::S_DVAR;
			rpzs_pkg::S_DVAR: begin
				ctl.start = 1'b1;
				u_num = prod_q[W-1] ? '0 : W'(prod_q) << 2;
				state_d = rpzs_pkg::S_DVARW;
			end
			rpzs_pkg::S_DVARW: if (!u_busy) state_d = rpzs_pkg::S_SQRT;
			rpzs_pkg::S_SQRT: begin
				ctl.start = 1'b1;
				ctl.is_sqrt = 1'b1;
				u_num = u_res;
				state_d = rpzs_pkg::S_SQRTW;
			end
			rpzs_pkg::S_SQRTW: if (!u_busy)
				state_d = (full_q || dev_r == '0) ? rpzs_pkg::S_OUT : rpzs_pkg::S_ZDIV;
			rpzs_pkg::S_ZDIV: begin
				ctl.start = 1'b1;
				u_num = mag + (den_q >> 1);
				state_d = rpzs_pkg::S_ZDIVW;
			end
			rpzs_pkg::S_ZDIVW: if (!u_busy) state_d = rpzs_pkg::S_OUT;
			rpzs_pkg::S_OUT: if (!m_axis_tvalid || m_axis_tready) state_d = rpzs_pkg::S_IDLE;
			default: state_d = rpzs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rpzs_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// Datapath and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && state_q != rpzs_pkg::S_OUT)
				m_axis_tvalid <= 1'b0;
			unique case (state_q)
				rpzs_pkg::S_IDLE: if (s_axis_tvalid) begin
					x_q <= s_axis_tdata;
					if (s_axis_tuser) begin
						cnt_q <= '0;
						sum_q <= '0;
						sq_q <= '0;
					end
				end
				rpzs_pkg::S_MUL1: begin
					full_q <= (cnt_q >= NW'(MAX_SET_LEN));
					mean_q <= '0;
					dev_q <= '0;
					z_q <= '0;
					status_q <= rpzs_pkg::ST_FEW;
					// n*Q
					prod_q <= $signed(W'(nq));
					acc_q <= W'(sum_q);
					den_q <= W'(cnt_q);
				end
				rpzs_pkg::S_MUL2: acc_q <= W'(ss);
				rpzs_pkg::S_MUL3: begin
					prod_q <= prod_q - acc_q;
					acc_q <= W'(sum_q);
				end
				rpzs_pkg::S_MEAN: neg_q <= acc_q[W-1];
				rpzs_pkg::S_MEANW: if (!u_busy) begin
					mean_q <= neg_q ? 16'(-u_res) : 16'(u_res);
					den_q <= W'(nn);
				end
				rpzs_pkg::S_SQRTW: if (!u_busy) begin
					dev_q <= devc;
					if (full_q) status_q <= rpzs_pkg::ST_LONG;
					else if (dev_r == '0) status_q <= rpzs_pkg::ST_ZERO;
					acc_q <= (W'(nx) - W'(sum_q)) <<< 8;
					den_q <= W'(ndev);
				end
				rpzs_pkg::S_ZDIV: neg_q <= acc_q[W-1];
				rpzs_pkg::S_ZDIVW: if (!u_busy) begin
					status_q <= rpzs_pkg::ST_OK;
					if (u_res > W'(32768) || (!neg_q && u_res == W'(32768)))
						z_q <= neg_q ? 16'sh8000 : 16'sh7FFF;
					else z_q <= neg_q ? 16'(-u_res) : 16'(u_res);
				end
				rpzs_pkg::S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
					m_axis_tvalid <= 1'b1;
					m_axis_tdata <= {5'd0, status_q, dev_q, mean_q, z_q};
					if (!full_q) begin
						cnt_q <= cnt_q + 1'b1;
						sum_q <= sum_q + SW'(x_q);
						sq_q <= sq_q + QW'($unsigned(xsq));
					end
				end
				default: ;
			endcase
		end
	end

	`CHK(a_cnt_max, cnt_q <= NW'(MAX_SET_LEN), "count above set length")
	`CHK(a_rdy_idle, s_axis_tready |-> !u_busy, "unit busy while idle")
	`CHK(a_out_one, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "accepted twice")
endmodule
